// File: design/fols_pkg.sv
`timescale 1ns / 1ps

package fols_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] REG_START_POSITION = 2'd2;
  localparam logic [1:0] REG_SEARCH_MODE    = 2'd3;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Search modes.
  localparam logic MODE_FIRST = 1'b0;
  localparam logic MODE_LAST  = 1'b1;

  // Control flags for one byte advancing through the search stage.
  typedef struct packed {
    logic go;
    logic last;
  } step_t;

  // Fields of one result request.
  typedef struct packed {
    logic        length_overflow;
    logic [15:0] match_position;
    logic        found;
  } result_t;

endpackage

// File: design/first_or_last_substring_search.sv
`timescale 1ns / 1ps

// Searches a byte stream for a configured pattern of up to MAX_PATTERN bytes.
// Text bytes arrive on the in_ channel, one per request, with in_tlast on
// the last byte of each text. For every text exactly one result request
// leaves on the out_ channel: the found flag, the start offset of the first
// or last match at or after start_position, and a flag that the text was
// longer than the 2^POSITION_BITS position counter.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wr_data between
// texts; writes take effect on the next byte.
// Throughput is one byte per cycle while no last byte waits for the output
// register: the window compare and the match bookkeeping finish in the
// single stage between the input register and the output register, which
// takes the result when the last byte leaves the input register.
// While out_tready is low, bytes other than the last keep flowing; a last
// byte waits in the input register until the held result is taken.
// Reset clears the configuration to zero, the byte window, the byte counter
// and the valid flags of both channel registers.

module first_or_last_substring_search #(
  parameter int MAX_PATTERN   = 8,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // text_byte
  input  logic        in_tlast,    // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // found, match_position[15:0], length_overflow
  input  logic        cfg_wr_en,
  input  logic [fols_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fols_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

  logic [63:0] pattern_bytes_r;
  logic [3:0]  pattern_length_r;
  logic [15:0] start_position_r;
  logic        search_mode_r;
  logic [3:0]  len_eff;

  logic        s1_valid_r;
  logic        s1_last_r;
  logic [7:0]  s1_byte_r;

  logic        out_valid_r;
  fols_pkg::result_t out_res_r;

  fols_pkg::step_t   step;
  fols_pkg::result_t res;
  logic              hit;
  logic              s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r  <= '0;
      pattern_length_r <= '0;
      start_position_r <= '0;
      search_mode_r    <= fols_pkg::MODE_FIRST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        fols_pkg::REG_PATTERN_BYTES:  pattern_bytes_r  <= cfg_wr_data;
        fols_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_wr_data[3:0];
        fols_pkg::REG_START_POSITION: start_position_r <= cfg_wr_data[15:0];
        fols_pkg::REG_SEARCH_MODE:    search_mode_r    <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign len_eff = (pattern_length_r > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN)
                                                        : pattern_length_r;

  // A last byte needs the output register free; other bytes never wait.
  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign step.go   = s1_go;
  assign step.last = s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  fols_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .text_byte     (s1_byte_r),
    .pattern_bytes (pattern_bytes_r),
    .pattern_len   (len_eff),
    .hit           (hit)
  );

  fols_tracker #(
    .POSITION_BITS (POSITION_BITS)
  ) u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .hit            (hit),
    .pattern_len    (len_eff),
    .start_position (start_position_r),
    .search_mode    (search_mode_r),
    .result         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r};

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("result raised without a last byte");

  a_no_found_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.found |-> out_res_r.match_position == 16'd0)
    else $error("position reported without a match");

endmodule

// File: design/fols_window.sv
`timescale 1ns / 1ps

module fols_window #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fols_pkg::step_t      step,
  input  logic [7:0]           text_byte,
  input  logic [63:0]          pattern_bytes,
  input  logic [3:0]           pattern_len,
  output logic                 hit
);

  logic [7:0] window_r [MAX_PATTERN];
  logic [7:0] cand     [MAX_PATTERN];

  // The window as it stands once the current byte has been shifted in.
  always_comb begin
    cand[0] = text_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      cand[i] = window_r[i-1];
    end
  end

  // Newest byte at index 0 lines up with the last pattern byte in use.
  always_comb begin
    logic [3:0] pidx;
    hit  = 1'b1;
    pidx = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pidx = pattern_len - 4'(i) - 4'd1;
      if (4'(i) < pattern_len) begin
        if (cand[i] != pattern_bytes[{pidx[2:0], 3'b000} +: 8]) begin
          hit = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_r[i] <= '0;
      end
    end else if (step.go) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        window_r[i] <= step.last ? 8'd0 : cand[i];
      end
    end
  end

endmodule

// File: design/fols_tracker.sv
`timescale 1ns / 1ps

module fols_tracker #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fols_pkg::step_t   step,
  input  logic              hit,
  input  logic [3:0]        pattern_len,
  input  logic [15:0]       start_position,
  input  logic              search_mode,
  output fols_pkg::result_t result
);

  localparam int CNT_W = POSITION_BITS + 1;
  localparam int EW    = (CNT_W > 16) ? CNT_W : 16;
  localparam logic [CNT_W-1:0] CAP     = {1'b1, {POSITION_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] CAP_P1  = {1'b1, {(POSITION_BITS-1){1'b0}}, 1'b1};

  logic [CNT_W-1:0]         bytes_r, bytes_nxt;
  logic                     seen_r, seen_nxt;
  logic [POSITION_BITS-1:0] kept_r, kept_nxt;

  logic                     below_cap;
  logic [CNT_W-1:0]         k1;
  logic [CNT_W-1:0]         len_w;
  logic [POSITION_BITS-1:0] start;
  logic                     take;
  logic [CNT_W-1:0]         n_cap;
  logic [POSITION_BITS-1:0] last_pos;
  logic                     empty_found;

  always_comb begin
    below_cap = !bytes_r[POSITION_BITS];
    k1        = bytes_r + CNT_W'(1);
    len_w     = CNT_W'(pattern_len);
    start     = POSITION_BITS'(k1 - len_w);
    take      = below_cap && (pattern_len != 4'd0) && (k1 >= len_w) && hit &&
                (EW'(start) >= EW'(start_position)) &&
                ((search_mode == fols_pkg::MODE_LAST) || !seen_r);
    seen_nxt  = seen_r | take;
    kept_nxt  = take ? start : kept_r;
    bytes_nxt = below_cap ? k1 : CAP_P1;
  end

  // The empty pattern matches at every start from zero up to the text length.
  always_comb begin
    n_cap       = (bytes_nxt > CAP) ? CAP : bytes_nxt;
    empty_found = EW'(start_position) <= EW'(n_cap);
    last_pos    = n_cap[POSITION_BITS] ? {POSITION_BITS{1'b1}}
                                       : n_cap[POSITION_BITS-1:0];
    result.length_overflow = bytes_nxt > CAP;
    if (pattern_len == 4'd0) begin
      result.found = empty_found;
      if (!empty_found) begin
        result.match_position = '0;
      end else if (search_mode == fols_pkg::MODE_FIRST) begin
        result.match_position = start_position;
      end else begin
        result.match_position = 16'(last_pos);
      end
    end else begin
      result.found          = seen_nxt;
      result.match_position = seen_nxt ? 16'(kept_nxt) : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
      seen_r  <= 1'b0;
      kept_r  <= '0;
    end else if (step.go) begin
      if (step.last) begin
        bytes_r <= '0;
        seen_r  <= 1'b0;
        kept_r  <= '0;
      end else begin
        bytes_r <= bytes_nxt;
        seen_r  <= seen_nxt;
        kept_r  <= kept_nxt;
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_r <= CAP_P1)
    else $error("byte count ran past its saturation value");

  a_clear_after_text: assert property (@(posedge clk) disable iff (!rst_n)
    step.go && step.last |=> (bytes_r == '0) && !seen_r)
    else $error("search state not cleared after the last byte");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_PATTERN  = 8;
  localparam int unsigned POS_CAP      = 1 << 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BYTES  = 335;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;    // text_byte
  logic                            in_tlast;    // end_of_text
  logic                            out_tvalid;
  logic                            out_tready;
  logic [23:0]                     out_tdata;   // found, match_position[15:0], length_overflow
  logic                            cfg_wr_en;
  logic [fols_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [fols_pkg::CFG_DATA_W-1:0] cfg_wr_data;

  first_or_last_substring_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow copy of the search configuration and per-text state.
  logic [63:0] pattern_bytes = '0;
  logic [3:0]  pattern_len   = '0;
  logic [15:0] start_pos     = '0;
  logic        search_mode   = fols_pkg::MODE_FIRST;
  logic [7:0]  window [MAX_PATTERN];
  int unsigned bytes_in_text = 0;
  bit          match_held    = 1'b0;
  logic [15:0] held_start    = '0;

  fols_pkg::result_t results_due [$];
  int unsigned send_idle_pct   = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_sent      = 0;
  int unsigned texts_sent      = 0;
  int unsigned cycle_count     = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("first_or_last_substring_search regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= ready_stall_pct);
  end

  // Advances the shadow state by one text byte and queues the result on the last one.
  task automatic search_step(input logic [7:0] b, input logic last);
    int unsigned       len, k, n, i, j;
    bit                hit;
    bit                found;
    logic [15:0]       pos;
    fols_pkg::result_t r;
    len = (pattern_len > MAX_PATTERN) ? MAX_PATTERN : pattern_len;
    k = bytes_in_text;
    for (i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i - 1];
    window[0] = b;
    if (k < POS_CAP) begin
      if (len > 0 && k + 1 >= len) begin
        hit = 1'b1;
        for (j = 0; j < len; j++) begin
          if (window[len - 1 - j] != pattern_bytes[8 * j +: 8]) hit = 1'b0;
        end
        if (hit && (k + 1 - len) >= start_pos) begin
          if (search_mode == fols_pkg::MODE_LAST || !match_held) begin
            held_start = 16'(k + 1 - len);
            match_held = 1'b1;
          end
        end
      end
      bytes_in_text = k + 1;
    end else begin
      bytes_in_text = POS_CAP + 1;
    end
    if (last) begin
      found = match_held;
      pos = held_start;
      if (len == 0) begin
        n = (bytes_in_text > POS_CAP) ? POS_CAP : bytes_in_text;
        found = (start_pos <= n);
        if (search_mode == fols_pkg::MODE_FIRST) pos = start_pos;
        else pos = (n >= POS_CAP) ? 16'hFFFF : 16'(n);
      end
      if (!found) pos = '0;
      r.found = found;
      r.match_position = pos;
      r.length_overflow = (bytes_in_text > POS_CAP);
      results_due.push_back(r);
      for (i = 0; i < MAX_PATTERN; i++) window[i] = '0;
      bytes_in_text = 0;
      match_held = 1'b0;
      held_start = '0;
      texts_sent++;
    end
  endtask

  // Called and returns at a falling edge, with in_tvalid low on return.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    search_step(b, last);
    bytes_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_text(input logic [7:0] text [$]);
    int unsigned i;
    for (i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic wait_idle();
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure_search(input logic [63:0] pbytes, input logic [3:0] plen,
                                  input logic [15:0] spos, input logic mode);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_addr = fols_pkg::REG_PATTERN_BYTES;
    cfg_wr_data = pbytes;
    @(negedge clk);
    cfg_addr = fols_pkg::REG_PATTERN_LENGTH;
    cfg_wr_data = 64'(plen);
    @(negedge clk);
    cfg_addr = fols_pkg::REG_START_POSITION;
    cfg_wr_data = 64'(spos);
    @(negedge clk);
    cfg_addr = fols_pkg::REG_SEARCH_MODE;
    cfg_wr_data = 64'(mode);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    pattern_bytes = pbytes;
    pattern_len = plen;
    start_pos = spos;
    search_mode = mode;
  endtask

  always @(posedge clk) begin
    fols_pkg::result_t want;
    fols_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[17:0];
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result request with no text pending: %h", $realtime, out_tdata);
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (got.found != want.found || got.match_position != want.match_position ||
            got.length_overflow != want.length_overflow || out_tdata[23:18] != '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: expected found=%0d pos=%0d ovf=%0d, got found=%0d pos=%0d ovf=%0d pad=%h",
                     $realtime, want.found, want.match_position, want.length_overflow,
                     got.found, got.match_position, got.length_overflow, out_tdata[23:18]);
        end
      end
    end
  end

  // Reset leaves an empty pattern in first mode, so a one-byte text matches at zero.
  task automatic test_reset_defaults();
    send_text('{8'h00});
  endtask

  task automatic test_pattern_extremes();
    configure_search(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 16'd0, fols_pkg::MODE_FIRST);
    send_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // A length above the window size is clipped to the full window.
    configure_search(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 16'd0, fols_pkg::MODE_LAST);
    send_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  task automatic test_start_and_short_text();
    configure_search(64'h0000_0000_6463_6261, 4'd4, 16'd0, fols_pkg::MODE_FIRST);
    send_text('{8'h61});
    configure_search(64'h0000_0000_0000_0061, 4'd1, 16'd1, fols_pkg::MODE_FIRST);
    send_text('{8'h61, 8'h00, 8'h61});
  endtask

  task automatic test_empty_pattern();
    configure_search(64'h0, 4'd0, 16'd2, fols_pkg::MODE_FIRST);
    send_text('{8'h55});
    configure_search(64'h0, 4'd0, 16'd0, fols_pkg::MODE_LAST);
    send_text('{8'hAA, 8'h55});
  endtask

  // A character search is the pattern search with the character's UTF-8 bytes.
  task automatic test_utf8_char();
    configure_search(64'h0000_0000_00AC_82E2, 4'd3, 16'd0, fols_pkg::MODE_LAST);
    send_text('{8'hE2, 8'h82, 8'hAC});
  endtask

  task automatic pick_random_config();
    logic [63:0] pbytes;
    logic [3:0]  plen;
    logic [15:0] spos;
    int unsigned r, i;
    pbytes = {$urandom, $urandom};
    if ($urandom_range(99) < 70) begin
      for (i = 0; i < MAX_PATTERN; i++) pbytes[8 * i +: 8] = 8'h61 + 8'($urandom_range(2));
    end
    r = $urandom_range(99);
    if (r < 10) plen = 4'd0;
    else if (r < 92) plen = 4'($urandom_range(1, 8));
    else plen = 4'($urandom_range(9, 15));
    r = $urandom_range(99);
    if (r < 35) spos = '0;
    else if (r < 80) spos = 16'($urandom_range(0, 30));
    else if (r < 90) spos = 16'hFFFF;
    else spos = 16'($urandom_range(0, 65535));
    configure_search(pbytes, plen, spos, 1'($urandom_range(1)));
  endtask

  // Texts are seeded with whole and partial copies of the pattern so matches are common.
  task automatic send_random_text();
    logic [7:0]  text [$];
    int unsigned n, plen_eff, r, i;
    plen_eff = (pattern_len > MAX_PATTERN) ? MAX_PATTERN : pattern_len;
    n = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
    while (text.size() < n) begin
      r = $urandom_range(99);
      if (plen_eff > 0 && r < 25) begin
        for (i = 0; i < plen_eff; i++) text.push_back(pattern_bytes[8 * i +: 8]);
      end else if (plen_eff > 0 && r < 65) begin
        text.push_back(pattern_bytes[8 * $urandom_range(plen_eff - 1) +: 8]);
      end else begin
        text.push_back(8'($urandom_range(255)));
      end
    end
    while (text.size() > n) void'(text.pop_back());
    send_text(text);
  endtask

  task automatic test_random_search(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned goal;
    wait_idle();
    send_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    goal = bytes_sent + PHASE_BYTES;
    while (bytes_sent < goal) begin
      pick_random_config();
      repeat ($urandom_range(1, 4)) send_random_text();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wr_data = '0;
    for (int i = 0; i < MAX_PATTERN; i++) window[i] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_pattern_extremes();
    test_start_and_short_text();
    test_empty_pattern();
    test_utf8_char();
    test_random_search(0, 0);
    test_random_search(72, 0);
    test_random_search(0, 72);
    test_random_search(16, 16);
    wait_idle();

    $display("Searched %0d texts (%0d bytes) in first and last mode with empty, short and",
             texts_sent, bytes_sent);
    $display("clipped patterns under idle and stall phases; %0d results compared, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("first_or_last_substring_search regression: pass");
    end else begin
      $display("first_or_last_substring_search regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fols_pkg.sv
design/fols_window.sv
design/fols_tracker.sv
design/first_or_last_substring_search.sv
bench/testbench.sv
